// File: src/zbrf_pkg.sv
package zbrf_pkg;

  localparam int unsigned NUM_WORDS_DEF = 32;
  localparam int unsigned ADDR_W        = 7;
  localparam int unsigned WIDX_W        = ADDR_W - 2;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LIMIT_W       = 6;
  localparam int unsigned RIGHTS_W      = 3;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [BYTE_W-1:0]   BYTE_MASK      = 8'hFF;
  localparam logic [LIMIT_W-1:0]  WORD_COUNT_RST = 6'd32;

  typedef enum logic [1:0] {
    CMD_RD_WORD = 2'd0,
    CMD_WR_WORD = 2'd1,
    CMD_RD_BYTE = 2'd2,
    CMD_WR_BYTE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_OUTSIDE   = 2'd2,
    ST_BADRIGHTS = 2'd3
  } status_e;

  typedef enum logic [RIGHTS_W-1:0] {
    RIGHTS_RNSWNS = 3'd0,
    RIGHTS_RNSWS  = 3'd1,
    RIGHTS_RONS   = 3'd2,
    RIGHTS_RSWS   = 3'd3,
    RIGHTS_NONE   = 3'd4
  } rights_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE1_START  = 3'd0,
    CFG_ZONE2_START  = 3'd1,
    CFG_WORD_COUNT   = 3'd2,
    CFG_ZONE0_RIGHTS = 3'd3,
    CFG_ZONE1_RIGHTS = 3'd4,
    CFG_ZONE2_RIGHTS = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_BUSY = 1'b1
  } fsm_state_e;

  typedef struct packed {
    logic capture;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// File: src/zbrf_ctrl.sv
module zbrf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  zbrf_pkg::dp_status_t  sts_i,
  output zbrf_pkg::ctrl_cmd_t   cmd_o
);
  import zbrf_pkg::*;

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.finish  = 1'b0;
    in_stall_o    = 1'b1;
    case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = FSM_BUSY;
        end
      end
      FSM_BUSY: begin
        // The result and the write-back both wait for room in the output register.
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_capture_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == FSM_BUSY)
    else $error("capture did not enter busy state");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == FSM_IDLE)
    else $error("finish did not return to idle");
  a_no_capture_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_BUSY |-> !cmd_o.capture)
    else $error("transfer accepted while busy");
`endif

endmodule

// File: src/zbrf_datapath.sv
module zbrf_datapath #(
  parameter int unsigned NUM_WORDS = zbrf_pkg::NUM_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [zbrf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zbrf_pkg::LIMIT_W-1:0]    cfg_data_i,
  input  logic [1:0]                      command_i,
  input  logic [zbrf_pkg::ADDR_W-1:0]     byte_address_i,
  input  logic [zbrf_pkg::DATA_W-1:0]     write_data_i,
  output logic [zbrf_pkg::DATA_W-1:0]     read_data_o,
  output logic [1:0]                      status_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  zbrf_pkg::ctrl_cmd_t             cmd_i,
  output zbrf_pkg::dp_status_t            sts_o
);
  import zbrf_pkg::*;

  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  // Configuration registers.
  logic [LIMIT_W-1:0]  zone1_start_q, zone2_start_q, word_count_q;
  logic [RIGHTS_W-1:0] zone0_rights_q, zone1_rights_q, zone2_rights_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone1_start_q  <= '0;
      zone2_start_q  <= '0;
      word_count_q   <= WORD_COUNT_RST;
      zone0_rights_q <= RIGHTS_NONE;
      zone1_rights_q <= RIGHTS_NONE;
      zone2_rights_q <= RIGHTS_NONE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ZONE1_START:  zone1_start_q  <= cfg_data_i;
        CFG_ZONE2_START:  zone2_start_q  <= cfg_data_i;
        CFG_WORD_COUNT:   word_count_q   <= cfg_data_i;
        CFG_ZONE0_RIGHTS: zone0_rights_q <= cfg_data_i[RIGHTS_W-1:0];
        CFG_ZONE1_RIGHTS: zone1_rights_q <= cfg_data_i[RIGHTS_W-1:0];
        CFG_ZONE2_RIGHTS: zone2_rights_q <= cfg_data_i[RIGHTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [1:0]        cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      addr_q  <= byte_address_i;
      wdata_q <= write_data_i;
    end
  end

  // Backup word storage; entries not yet written read as zero.
  logic [DATA_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_q;
  logic [DATA_W-1:0]    mem_rd_q;
  logic                 valid_rd_q;
  logic [WIDX_W-1:0]    rd_widx;
  logic                 rd_in_range;
  logic [AW-1:0]        rd_idx, wr_idx;
  logic                 mem_we;
  logic [DATA_W-1:0]    mem_wdata;

  assign rd_widx     = byte_address_i[ADDR_W-1:2];
  assign rd_in_range = 32'(rd_widx) < NUM_WORDS;
  assign rd_idx      = AW'(rd_widx);
  assign wr_idx      = AW'(addr_q[ADDR_W-1:2]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= mem_wdata;
    end
    if (cmd_i.capture && rd_in_range) begin
      mem_rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.capture) begin
        valid_rd_q <= rd_in_range && valid_q[rd_idx];
      end
    end
  end

  // Zone lookup and rights check.
  logic [WIDX_W-1:0]   widx;
  logic [LIMIT_W-1:0]  widx_ext;
  logic                in_zone;
  logic [RIGHTS_W-1:0] rights;
  logic                readable, writable, bad_rights;
  logic [DATA_W-1:0]   word_rd;
  logic [1:0]          rd_status, wr_status;
  logic [4:0]          sh;
  logic [BYTE_W-1:0]   byte_rd;
  logic [DATA_W-1:0]   merged;
  logic [DATA_W-1:0]   result_data;
  logic [1:0]          result_status;
  logic                do_write;

  assign widx     = addr_q[ADDR_W-1:2];
  assign widx_ext = LIMIT_W'(widx);

  always_comb begin
    in_zone = 1'b1;
    rights  = zone2_rights_q;
    if (32'(widx) >= NUM_WORDS) begin
      in_zone = 1'b0;
    end else if (widx_ext < zone1_start_q) begin
      rights = zone0_rights_q;
    end else if (widx_ext < zone2_start_q) begin
      rights = zone1_rights_q;
    end else if (widx_ext >= word_count_q) begin
      in_zone = 1'b0;
    end
  end

  always_comb begin
    readable   = 1'b0;
    writable   = 1'b0;
    bad_rights = 1'b0;
    case (rights)
      RIGHTS_RNSWNS, RIGHTS_RNSWS, RIGHTS_RSWS: begin
        readable = 1'b1;
        writable = 1'b1;
      end
      RIGHTS_RONS: readable = 1'b1;
      RIGHTS_NONE: ;
      default: bad_rights = 1'b1;
    endcase
  end

  always_comb begin
    word_rd = '0;
    if (in_zone && readable && valid_rd_q) begin
      word_rd = mem_rd_q;
    end
    if (!in_zone) begin
      rd_status = ST_OUTSIDE;
      wr_status = ST_OUTSIDE;
    end else if (bad_rights) begin
      rd_status = ST_BADRIGHTS;
      wr_status = ST_BADRIGHTS;
    end else begin
      rd_status = ST_DONE;
      wr_status = writable ? ST_DONE : ST_DROPPED;
    end
  end

  assign sh      = {addr_q[1:0], 3'b000};
  assign byte_rd = BYTE_W'(word_rd >> sh) & BYTE_MASK;
  assign merged  = (word_rd & ~(DATA_W'(BYTE_MASK) << sh))
                 | (DATA_W'(wdata_q[BYTE_W-1:0]) << sh);

  always_comb begin
    result_data   = '0;
    result_status = rd_status;
    mem_wdata     = wdata_q;
    do_write      = 1'b0;
    case (cmd_q)
      CMD_RD_WORD: result_data = word_rd;
      CMD_WR_WORD: begin
        result_status = wr_status;
        do_write      = in_zone && writable;
      end
      CMD_RD_BYTE: result_data = DATA_W'(byte_rd);
      CMD_WR_BYTE: begin
        result_status = wr_status;
        mem_wdata     = merged;
        do_write      = in_zone && writable;
      end
      default: ;
    endcase
  end

  assign mem_we = cmd_i.finish && do_write;

  // Output register.
  logic              out_valid_q;
  logic [DATA_W-1:0] read_data_q;
  logic [1:0]        status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      read_data_q <= result_data;
      status_q    <= result_status;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign read_data_o    = read_data_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("result not loaded into output register");
  a_no_write_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && result_status != ST_DONE) |-> !mem_we)
    else $error("storage written on a failed or dropped transfer");
  a_error_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_DONE) |-> read_data_q == '0)
    else $error("nonzero read data with error status");
`endif

endmodule

// File: src/zoned_backup_register_file.sv
// A result is loaded into the output register by the execute state that follows its capture.
// The block takes no new access until the last one is finished; capture reads the storage and the
// execute state then does the zone lookup, byte merge and write-back.
// A stalled output holds the execute cycle until the output register frees.
// Reset: asynchronous, active low; configuration returns to its defaults and
// the per-word valid bits clear at once, so every backup word reads as zero.
module zoned_backup_register_file #(
  parameter int unsigned NUM_WORDS = zbrf_pkg::NUM_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [zbrf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zbrf_pkg::LIMIT_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      command_i,
  input  logic [zbrf_pkg::ADDR_W-1:0]     byte_address_i,
  input  logic [zbrf_pkg::DATA_W-1:0]     write_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [zbrf_pkg::DATA_W-1:0]     read_data_o,
  output logic [1:0]                      status_o
);
  import zbrf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready_o = 1'b1;

  zbrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  zbrf_datapath #(
    .NUM_WORDS (NUM_WORDS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (command_i),
    .byte_address_i (byte_address_i),
    .write_data_i   (write_data_i),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// File: dv/testbench.sv
module testbench;
  import zbrf_pkg::*;

  localparam int unsigned ZONES         = 3;
  localparam int unsigned NO_ZONE       = ZONES;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 105;

  // Rights codes past the defined set.
  localparam logic [RIGHTS_W-1:0] RIGHTS_BAD_A = 3'd5;
  localparam logic [RIGHTS_W-1:0] RIGHTS_BAD_B = 3'd6;
  localparam logic [RIGHTS_W-1:0] RIGHTS_BAD_C = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_e           status;
  } access_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           command = '0;
  logic [ADDR_W-1:0]    byte_address = '0;
  logic [DATA_W-1:0]    write_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    read_data;
  logic [1:0]           status;

  // Shadow copy of the block's configuration and storage.
  logic [LIMIT_W-1:0]   zone1_begin;
  logic [LIMIT_W-1:0]   zone2_begin;
  logic [LIMIT_W-1:0]   words_in_use;
  logic [RIGHTS_W-1:0]  zone_rights [ZONES];
  logic [DATA_W-1:0]    backup_copy [NUM_WORDS_DEF];

  access_result_t pending_results [$];
  int unsigned    errors = 0;
  int unsigned    accesses_sent = 0;
  int unsigned    settings_used = 0;
  int unsigned    status_tally [4] = '{0, 0, 0, 0};
  int unsigned    cycle_count = 0;
  bit             quiet = 1'b0;

  zoned_backup_register_file #(
    .NUM_WORDS(NUM_WORDS_DEF)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .byte_address_i(byte_address),
    .write_data_i  (write_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_o   (read_data),
    .status_o      (status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 29);
  end

  // Result checker: every transfer on the output side is matched against the
  // oldest prediction.
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      status_tally[status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: read_data=%h status=%0d",
                 $time, read_data, status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.data) begin
          $display("%0t: read_data mismatch: expected %h, actual %h",
                   $time, want.data, read_data);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned zone_of(input logic [WIDX_W-1:0] widx);
    if (widx < zone1_begin) return 0;
    if (widx < zone2_begin) return 1;
    if (widx < words_in_use) return 2;
    return NO_ZONE;
  endfunction

  function automatic status_e fetch_word(input logic [WIDX_W-1:0] widx,
                                         output logic [DATA_W-1:0] word);
    int unsigned z;
    z = zone_of(widx);
    word = '0;
    if (z == NO_ZONE) return ST_OUTSIDE;
    case (zone_rights[z])
      RIGHTS_RNSWNS, RIGHTS_RNSWS, RIGHTS_RONS, RIGHTS_RSWS: begin
        word = backup_copy[widx];
        return ST_DONE;
      end
      RIGHTS_NONE: return ST_DONE;
      default: return ST_BADRIGHTS;
    endcase
  endfunction

  function automatic status_e store_word(input logic [WIDX_W-1:0] widx,
                                         input logic [DATA_W-1:0] word);
    int unsigned z;
    z = zone_of(widx);
    if (z == NO_ZONE) return ST_OUTSIDE;
    case (zone_rights[z])
      RIGHTS_RNSWNS, RIGHTS_RNSWS, RIGHTS_RSWS: begin
        backup_copy[widx] = word;
        return ST_DONE;
      end
      RIGHTS_RONS, RIGHTS_NONE: return ST_DROPPED;
      default: return ST_BADRIGHTS;
    endcase
  endfunction

  function automatic void predict_access(input cmd_e cmd, input logic [ADDR_W-1:0] addr,
                                         input logic [DATA_W-1:0] wdata);
    logic [WIDX_W-1:0] widx;
    logic [DATA_W-1:0] cur;
    access_result_t    res;
    widx = addr[ADDR_W-1:2];
    res.data = '0;
    res.status = ST_DONE;
    case (cmd)
      CMD_RD_WORD: begin
        res.status = fetch_word(widx, cur);
        res.data = cur;
      end
      CMD_WR_WORD: res.status = store_word(widx, wdata);
      CMD_RD_BYTE: begin
        res.status = fetch_word(widx, cur);
        res.data = {{(DATA_W-BYTE_W){1'b0}}, cur[addr[1:0]*BYTE_W +: BYTE_W]};
      end
      CMD_WR_BYTE: begin
        // The merge starts from whatever the read path returns, which is zero
        // for a zone without read access.
        void'(fetch_word(widx, cur));
        cur[addr[1:0]*BYTE_W +: BYTE_W] = wdata[BYTE_W-1:0];
        res.status = store_word(widx, cur);
      end
      default: ;
    endcase
    pending_results.push_back(res);
  endfunction

  task automatic send_access(input cmd_e cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    if (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 29);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    byte_address <= addr;
    write_data   <= wdata;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_access(cmd, addr, wdata);
    accesses_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ZONE1_START:  zone1_begin = value;
      CFG_ZONE2_START:  zone2_begin = value;
      CFG_WORD_COUNT:   words_in_use = value;
      CFG_ZONE0_RIGHTS: zone_rights[0] = value[RIGHTS_W-1:0];
      CFG_ZONE1_RIGHTS: zone_rights[1] = value[RIGHTS_W-1:0];
      CFG_ZONE2_RIGHTS: zone_rights[2] = value[RIGHTS_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_zones(input logic [LIMIT_W-1:0] z1, input logic [LIMIT_W-1:0] z2,
                               input logic [LIMIT_W-1:0] count,
                               input logic [RIGHTS_W-1:0] r0,
                               input logic [RIGHTS_W-1:0] r1,
                               input logic [RIGHTS_W-1:0] r2);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_ZONE1_START, z1);
    write_reg(CFG_ZONE2_START, z2);
    write_reg(CFG_WORD_COUNT, count);
    write_reg(CFG_ZONE0_RIGHTS, {{(LIMIT_W-RIGHTS_W){1'b0}}, r0});
    write_reg(CFG_ZONE1_RIGHTS, {{(LIMIT_W-RIGHTS_W){1'b0}}, r1});
    write_reg(CFG_ZONE2_RIGHTS, {{(LIMIT_W-RIGHTS_W){1'b0}}, r2});
    settings_used++;
  endtask

  function automatic logic [RIGHTS_W-1:0] pick_rights();
    // Writable codes dominate so that stored data builds up and reads see it.
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(2))
        0: return RIGHTS_RNSWNS;
        1: return RIGHTS_RNSWS;
        default: return RIGHTS_RSWS;
      endcase
    end
    return RIGHTS_W'($urandom_range(7));
  endfunction

  task automatic test_reset_defaults();
    zone1_begin  = '0;
    zone2_begin  = '0;
    words_in_use = WORD_COUNT_RST;
    foreach (zone_rights[z]) zone_rights[z] = RIGHTS_NONE;
    foreach (backup_copy[w]) backup_copy[w] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // After reset every word sits in zone 2 with no access at all.
    send_access(CMD_WR_WORD, 7'd0, 32'hFFFF_FFFF);
    send_access(CMD_RD_WORD, 7'd0, 32'h0);
    send_access(CMD_WR_BYTE, 7'd127, 32'hFF);
    send_access(CMD_RD_BYTE, 7'd127, 32'h0);
  endtask

  task automatic test_directed_zones();
    program_zones(6'd8, 6'd16, 6'd24, RIGHTS_RNSWNS, RIGHTS_RONS, RIGHTS_RSWS);
    send_access(CMD_WR_WORD, 7'd0, 32'hFFFF_FFFF);
    send_access(CMD_RD_WORD, 7'd3, 32'h0);
    send_access(CMD_WR_BYTE, 7'd1, 32'hFFFF_FF00);
    send_access(CMD_RD_BYTE, 7'd1, 32'h0);
    send_access(CMD_RD_BYTE, 7'd3, 32'h0);
    send_access(CMD_WR_WORD, 7'd40, 32'h1234_5678);
    send_access(CMD_RD_WORD, 7'd40, 32'h0);
    send_access(CMD_WR_WORD, 7'd64, 32'hA5A5_5A5A);
    send_access(CMD_WR_BYTE, 7'd66, 32'h0000_01FF);
    send_access(CMD_RD_WORD, 7'd64, 32'h0);
    send_access(CMD_RD_WORD, 7'd92, 32'h0);
    send_access(CMD_RD_BYTE, 7'd96, 32'h0);
    send_access(CMD_WR_BYTE, 7'd127, 32'hFF);
    send_access(CMD_RD_WORD, 7'd124, 32'h0);
    // Invalid rights on zone 1, no access on zone 2.
    program_zones(6'd8, 6'd16, 6'd24, RIGHTS_RNSWNS, RIGHTS_BAD_A, RIGHTS_NONE);
    send_access(CMD_RD_WORD, 7'd40, 32'h0);
    send_access(CMD_WR_BYTE, 7'd41, 32'h55);
    send_access(CMD_RD_WORD, 7'd64, 32'h0);
    send_access(CMD_WR_WORD, 7'd64, 32'h0);
    // Zone 2 starts below zone 1, so zone 1 is empty and its bad code unused.
    program_zones(6'd8, 6'd4, 6'd24, RIGHTS_RNSWS, RIGHTS_BAD_C, RIGHTS_RSWS);
    send_access(CMD_RD_WORD, 7'd40, 32'h0);
    send_access(CMD_RD_BYTE, 7'd66, 32'h0);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned       span;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    span = (32'(words_in_use) == 0 || 32'(words_in_use) > NUM_WORDS_DEF) ? NUM_WORDS_DEF
                                                                         : 32'(words_in_use);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      if ($urandom_range(9) < 8) addr = ADDR_W'($urandom_range(span * 4 - 1));
      else addr = ADDR_W'($urandom_range(127));
      case ($urandom_range(9))
        0: wdata = '1;
        1: wdata = '0;
        default: wdata = $urandom();
      endcase
      send_access(cmd_e'($urandom_range(3)), addr, wdata);
    end
  endtask

  task automatic test_random_traffic();
    logic [LIMIT_W-1:0] z1;
    logic [LIMIT_W-1:0] z2;
    // Extreme layouts first: one big zone each way, a single word, values past
    // their range, and nothing in use at all.
    program_zones(6'd0, 6'd0, 6'd32, RIGHTS_RNSWS, RIGHTS_RNSWS, RIGHTS_RNSWS);
    random_phase(PHASE_ITEMS);
    program_zones(6'd32, 6'd32, 6'd32, RIGHTS_RSWS, RIGHTS_NONE, RIGHTS_RONS);
    random_phase(PHASE_ITEMS);
    program_zones(6'd0, 6'd0, 6'd1, RIGHTS_NONE, RIGHTS_RONS, RIGHTS_RNSWNS);
    random_phase(PHASE_ITEMS);
    program_zones(6'd63, 6'd0, 6'd63, RIGHTS_RNSWNS, RIGHTS_BAD_B, RIGHTS_BAD_A);
    random_phase(PHASE_ITEMS);
    program_zones(6'd0, 6'd0, 6'd0, RIGHTS_RNSWNS, RIGHTS_RNSWNS, RIGHTS_RNSWNS);
    random_phase(PHASE_ITEMS / 3);
    for (int unsigned p = 0; p < 6; p++) begin
      z1 = LIMIT_W'($urandom_range(32));
      z2 = LIMIT_W'($urandom_range(32));
      if ($urandom_range(3) != 0 && z2 < z1) begin
        z1 = z1 ^ z2;
        z2 = z1 ^ z2;
        z1 = z1 ^ z2;
      end
      program_zones(z1, z2, LIMIT_W'($urandom_range(1, 32)), pick_rights(),
                    pick_rights(), pick_rights());
      quiet = (p == 2);
      random_phase(PHASE_ITEMS);
      quiet = 1'b0;
    end
  endtask

  initial begin
    test_reset_defaults();
    test_directed_zones();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d accesses under %0d register settings.", accesses_sent,
             settings_used);
    $display("Results seen: %0d done, %0d dropped, %0d outside, %0d bad rights.",
             status_tally[ST_DONE], status_tally[ST_DROPPED], status_tally[ST_OUTSIDE],
             status_tally[ST_BADRIGHTS]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/zbrf_pkg.sv
src/zbrf_ctrl.sv
src/zbrf_datapath.sv
src/zoned_backup_register_file.sv
dv/testbench.sv
